>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks sampled on the rising clock edge, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checks that must also hold while reset is high
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/rhrle_pkg.sv
`timescale 1ns / 1ps

package rhrle_pkg;

   // result queue
   localparam int unsigned QDepth = 4;
   localparam int unsigned QPtrW  = 2;
   localparam int unsigned QCntW  = 3;

   // loss codes and chunk size
   localparam logic [7:0] CODE_BLOCKED = 8'd1;
   localparam logic [7:0] CODE_MISSED  = 8'd2;
   localparam logic [7:0] CODE_MERGED  = 8'd3;
   localparam logic [7:0] CHUNK        = 8'hFF;
   localparam logic [7:0] FULL_HIST    = 8'hFF;

   // register reset values
   localparam logic [7:0] BLOCK_ENTER_RST = 8'd4;
   localparam logic [7:0] BLOCK_LEAVE_RST = 8'd8;
   localparam logic [7:0] RESERVE_RST     = 8'd2;
   localparam logic [3:0] DRIFT_RST       = 4'd4;

   typedef enum logic [1:0] {
      CSR_BLOCK_ENTER = 2'd0,
      CSR_BLOCK_LEAVE = 2'd1,
      CSR_RESERVE     = 2'd2,
      CSR_DRIFT       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] run_value;
      logic [7:0] run_count;
      logic       last;
   } pair_type;

   typedef struct packed {
      logic [1:0]  num;
      pair_type    p0;
      pair_type    p1;
      logic [15:0] cnt;
   } flush_type;

   function automatic logic [3:0] ones8(input logic [7:0] x);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, x[i]};
      end
      return n;
   endfunction

   // split off a full chunk if needed, then close the run if it ended
   function automatic flush_type flush_run(input logic [7:0] lvl, input logic [15:0] cnt,
                                           input logic ended);
      flush_type f;
      f     = '0;
      f.cnt = cnt;
      if (cnt > {8'd0, CHUNK}) begin
         f.p0  = '{run_value: lvl, run_count: CHUNK, last: 1'b0};
         f.num = 2'd1;
         f.cnt = cnt - {8'd0, CHUNK};
      end
      if (ended) begin
         if (f.num == 2'd0) begin
            f.p0 = '{run_value: lvl, run_count: f.cnt[7:0], last: 1'b0};
         end else begin
            f.p1 = '{run_value: lvl, run_count: f.cnt[7:0], last: 1'b0};
         end
         f.num = f.num + 2'd1;
         f.cnt = 16'd0;
      end
      return f;
   endfunction

endpackage

>>> hdl/rhrle_req_if.sv
`timescale 1ns / 1ps

interface rhrle_req_if;
   logic              valid;
   logic              ready;
   logic              mode;
   logic signed [7:0] rssi;
   logic [7:0]        free_space;

   modport source (output valid, mode, rssi, free_space, input ready);
   modport sink (input valid, mode, rssi, free_space, output ready);
endinterface

>>> hdl/rhrle_rsp_if.sv
`timescale 1ns / 1ps

interface rhrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] run_value;
   logic [7:0] run_count;
   logic       last;

   modport source (output valid, run_value, run_count, last, input ready);
   modport sink (input valid, run_value, run_count, last, output ready);
endinterface

>>> hdl/rssi_hysteresis_run_length_encoder_unit.sv
`timescale 1ns / 1ps
// a transaction is registered on accept in the input stage; when the result queue has room it
// is processed and its pairs are written into the queue, whose head drives the result port
// throughput: one request per cycle while each yields at most one pair and the result port
// takes pairs; a request waits in the input stage while the queue holds more than two pairs
// reset (synchronous, active high) clears level, counter, histories, blocked and the queue,
// and loads the thresholds with 4, 8, 2 and 4

`include "assert_macros.svh"

module rssi_hysteresis_run_length_encoder_unit import rhrle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rhrle_req_if.sink   req_ch,
   rhrle_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   // thresholds
   logic [7:0] block_enter_ff, block_leave_ff, reserve_ff;
   logic [3:0] drift_ff;

   // encoder state
   logic [7:0]  level_ff, level_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  match_ff, match_in;
   logic [7:0]  above_ff, above_in;
   logic [7:0]  below_ff, below_in;
   logic        blocked_ff, blocked_in;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_mode_ff;
   logic [7:0] s1_value_ff;
   logic [7:0] s1_free_ff;

   // result queue
   pair_type         q_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] q_cnt_ff, q_cnt_in;

   logic      req_accept, proc, pop;
   flush_type res;

   assign proc       = s1_valid_ff && (q_cnt_ff <= QCntW'(QDepth - 2));
   assign req_ch.ready = !s1_valid_ff || proc;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign pop        = rsp_ch.valid && rsp_ch.ready;

   assign s1_valid_in = req_accept ? 1'b1 : (proc ? 1'b0 : s1_valid_ff);

   // encoder step
   always_comb begin
      logic [7:0] code;
      logic [8:0] diff;
      logic       is_loss;
      flush_type  f;
      level_in   = level_ff;
      count_in   = count_ff;
      match_in   = match_ff;
      above_in   = above_ff;
      below_in   = below_ff;
      blocked_in = blocked_ff;
      res        = '0;
      f          = '0;
      code       = s1_mode_ff ? CODE_MISSED : CODE_BLOCKED;
      is_loss    = s1_mode_ff || (s1_free_ff <= block_enter_ff) || blocked_ff;
      diff       = {1'b0, s1_value_ff} - {1'b0, level_ff};
      if (is_loss) begin
         if (level_ff != code) begin
            if (s1_free_ff <= reserve_ff) begin
               level_in = CODE_MERGED;
               count_in = count_ff + 16'd1;
            end else begin
               res      = flush_run(level_ff, count_ff, 1'b1);
               count_in = res.cnt;
               level_in = code;
            end
         end else begin
            count_in = count_ff + 16'd1;
         end
         if (!s1_mode_ff) begin
            blocked_in = !(s1_free_ff >= block_leave_ff);
         end
      end else begin
         match_in = {match_ff[6:0], 1'b0};
         above_in = {above_ff[6:0], 1'b0};
         below_in = {below_ff[6:0], 1'b0};
         if (diff == 9'd1) begin
            above_in[0] = 1'b1;
            match_in[0] = 1'b1;
         end else if (diff == 9'd0) begin
            match_in[0] = 1'b1;
         end else if (diff == 9'h1FF) begin
            below_in[0] = 1'b1;
            match_in[0] = 1'b1;
         end
         if (!match_in[0]) begin
            // run broken: credit the pending matches, close it, restart at the sample
            res      = flush_run(level_ff, count_ff + {12'd0, ones8(match_in)}, 1'b1);
            count_in = res.cnt;
            level_in = s1_value_ff;
            match_in = 8'd1;
         end else if (match_in == FULL_HIST) begin
            if (below_in == 8'd0 && ones8(above_in) > drift_ff) begin
               res      = flush_run(level_ff, count_ff + 16'd1, 1'b1);
               below_in = ~above_in;
               above_in = 8'd0;
               level_in = level_ff + 8'd1;
            end else if (above_in == 8'd0 && ones8(below_in) > drift_ff) begin
               res      = flush_run(level_ff, count_ff + 16'd1, 1'b1);
               above_in = ~below_in;
               below_in = 8'd0;
               level_in = level_ff - 8'd1;
            end else begin
               res = flush_run(level_ff, count_ff + 16'd1, 1'b0);
            end
            count_in = res.cnt;
         end
      end
      if (res.num == 2'd1) begin
         res.p0.last = 1'b1;
      end else if (res.num == 2'd2) begin
         res.p1.last = 1'b1;
      end
      f = res;
      if (!proc) begin
         f = '0;
      end
      res = f;
   end

   always_comb begin
      q_cnt_in = q_cnt_ff + QCntW'(res.num) - QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_enter_ff <= BLOCK_ENTER_RST;
         block_leave_ff <= BLOCK_LEAVE_RST;
         reserve_ff     <= RESERVE_RST;
         drift_ff       <= DRIFT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BLOCK_ENTER: block_enter_ff <= csr_wdata;
            CSR_BLOCK_LEAVE: block_leave_ff <= csr_wdata;
            CSR_RESERVE:     reserve_ff     <= csr_wdata;
            CSR_DRIFT:       drift_ff       <= csr_wdata[3:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         count_ff   <= '0;
         match_ff   <= '0;
         above_ff   <= '0;
         below_ff   <= '0;
         blocked_ff <= 1'b0;
      end else if (proc) begin
         level_ff   <= level_in;
         count_ff   <= count_in;
         match_ff   <= match_in;
         above_ff   <= above_in;
         below_ff   <= below_in;
         blocked_ff <= blocked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff  <= req_ch.mode;
         s1_value_ff <= {~req_ch.rssi[7], req_ch.rssi[6:0]};
         s1_free_ff  <= req_ch.free_space;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPtrW'(res.num);
         rd_ptr_ff <= rd_ptr_ff + QPtrW'(pop);
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.num != 2'd0) begin
         q_ff[wr_ptr_ff] <= res.p0;
      end
      if (res.num == 2'd2) begin
         q_ff[wr_ptr_ff + QPtrW'(1)] <= res.p1;
      end
   end

   assign rsp_ch.valid     = q_cnt_ff != '0;
   assign rsp_ch.run_value = q_ff[rd_ptr_ff].run_value;
   assign rsp_ch.run_count = q_ff[rd_ptr_ff].run_count;
   assign rsp_ch.last      = q_ff[rd_ptr_ff].last;

   `ASSERT_CLK(a_queue_bound, q_cnt_ff <= QCntW'(QDepth), "result queue overrun")
   `ASSERT_CLK_ALWAYS(a_reset_empties, reset |=> (q_cnt_ff == '0), "queue not cleared")
   `ASSERT_CLK(a_push_shows, (res.num != 2'd0) |=> (q_cnt_ff != '0), "pushed pair not offered")
   `ASSERT_CLK(a_full_stage_drains, (req_accept && s1_valid_ff) |-> proc, "stage overwritten")
   `ASSERT_CLK(a_level_hold, !proc |=> $stable(level_ff), "level moved without a transaction")

endmodule
